/* hdl/u8vc_pkg.sv */
// Package: shared types and constants for the UTF-8 validator and codepoint counter.
`timescale 1ns / 1ps
`default_nettype none
package u8vc_pkg;

	localparam int COUNT_BITS_DEFAULT = 31;
	localparam int OUT_COUNT_W        = 31;
	localparam int QUEUE_DEPTH        = 4;

	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD_MIN   = 8'hC2;
	localparam logic [7:0] LEAD_MAX   = 8'hF4;
	localparam logic [7:0] LEAD2_MAX  = 8'hDF;
	localparam logic [7:0] LEAD3_MAX  = 8'hEF;
	localparam logic [7:0] LEAD_E0    = 8'hE0;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] CONT_MIN   = 8'h80;
	localparam logic [7:0] CONT_MAX   = 8'hBF;
	localparam logic [7:0] CONT_E0_LO = 8'hA0;
	localparam logic [7:0] CONT_F0_LO = 8'h90;
	localparam logic [7:0] CONT_ED_HI = 8'h9F;
	localparam logic [7:0] CONT_F4_HI = 8'h8F;

	typedef enum logic [2:0] {
		LK_OTHER,
		LK_E0,
		LK_ED,
		LK_F0,
		LK_F4
	} lead_kind_t;

	typedef struct packed {
		logic       is_nul;
		logic       is_ascii;
		logic       lead_ok;
		logic [1:0] lead_len;
		lead_kind_t lead_kind;
		logic       cont_any;
		logic       ge_a0;
		logic       le_9f;
		logic       ge_90;
		logic       le_8f;
	} byte_class_t;

endpackage
`default_nettype wire

/* hdl/u8vc_if.sv */
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface u8vc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8vc_result_if;
	logic        valid;
	logic        ready;
	logic [30:0] codepoint_count;
	logic        is_valid;

	modport source (output valid, output codepoint_count, output is_valid, input ready);
	modport sink   (input valid, input codepoint_count, input is_valid, output ready);
endinterface
`default_nettype wire

/* hdl/u8vc_front.sv */
// Front end: accepts bytes and classifies them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module u8vc_front (
	u8vc_byte_if.sink           byte_in,
	input  wire logic           q_full,
	output logic                q_push,
	output u8vc_pkg::byte_class_t q_item
);
	import u8vc_pkg::*;

	logic [7:0] b;

	assign b              = byte_in.data_byte;
	assign byte_in.ready  = !q_full;
	assign q_push         = byte_in.valid && !q_full;

	always_comb begin
		q_item          = '0;
		q_item.is_nul   = (b == BYTE_NUL);
		q_item.is_ascii = (b <= ASCII_MAX);
		q_item.lead_ok  = (b >= LEAD_MIN) && (b <= LEAD_MAX);
		if (b <= LEAD2_MAX) begin
			q_item.lead_len = 2'd1;
		end else if (b <= LEAD3_MAX) begin
			q_item.lead_len = 2'd2;
		end else begin
			q_item.lead_len = 2'd3;
		end
		unique case (b)
			LEAD_E0: q_item.lead_kind = LK_E0;
			LEAD_ED: q_item.lead_kind = LK_ED;
			LEAD_F0: q_item.lead_kind = LK_F0;
			LEAD_F4: q_item.lead_kind = LK_F4;
			default: q_item.lead_kind = LK_OTHER;
		endcase
		q_item.cont_any = (b >= CONT_MIN) && (b <= CONT_MAX);
		q_item.ge_a0    = (b >= CONT_E0_LO);
		q_item.le_9f    = (b <= CONT_ED_HI);
		q_item.ge_90    = (b >= CONT_F0_LO);
		q_item.le_8f    = (b <= CONT_F4_HI);
	end
endmodule
`default_nettype wire

/* hdl/u8vc_queue.sv */
// Short queue of classified bytes between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module u8vc_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  u8vc_pkg::byte_class_t      push_item,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       not_empty,
	output u8vc_pkg::byte_class_t      head_item
);
	import u8vc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	byte_class_t        entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;

	assign full      = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/u8vc_back.sv */
// Back end: sequence state, codepoint count and result register.
`timescale 1ns / 1ps
`default_nettype none
module u8vc_back #(
	parameter int COUNT_BITS = u8vc_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_not_empty,
	input  u8vc_pkg::byte_class_t  q_head,
	output logic                   q_pop,
	u8vc_result_if.source          result_out
);
	import u8vc_pkg::*;

	localparam int WIDE_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

	logic [1:0]            pending_q;
	lead_kind_t            kind_q;
	logic                  second_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  err_q;

	logic                  res_valid_q;
	logic [OUT_COUNT_W-1:0] res_count_q;
	logic                  res_ok_q;

	logic                  slot_free;
	logic                  cont_ok;
	logic                  string_ok;
	logic [WIDE_W-1:0]     count_wide;

	assign slot_free  = !res_valid_q || result_out.ready;
	assign q_pop      = q_not_empty && (!q_head.is_nul || slot_free);
	assign string_ok  = !err_q && (pending_q == 2'd0);
	assign count_wide = WIDE_W'(count_q);

	always_comb begin
		cont_ok = q_head.cont_any;
		if (second_q) begin
			unique case (kind_q)
				LK_E0:    cont_ok = q_head.cont_any && q_head.ge_a0;
				LK_ED:    cont_ok = q_head.cont_any && q_head.le_9f;
				LK_F0:    cont_ok = q_head.cont_any && q_head.ge_90;
				LK_F4:    cont_ok = q_head.cont_any && q_head.le_8f;
				default:  cont_ok = q_head.cont_any;
			endcase
		end
	end

	assign result_out.valid           = res_valid_q;
	assign result_out.codepoint_count = res_count_q;
	assign result_out.is_valid        = res_ok_q;

	always_ff @(posedge clk) begin
		if (q_pop && q_head.is_nul) begin
			res_count_q <= string_ok ? count_wide[OUT_COUNT_W-1:0] : '0;
			res_ok_q    <= string_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			kind_q      <= LK_OTHER;
			second_q    <= 1'b0;
			count_q     <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_head.is_nul) begin
				res_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_head.is_nul) begin
					pending_q   <= '0;
					kind_q      <= LK_OTHER;
					second_q    <= 1'b0;
					count_q     <= '0;
					err_q       <= 1'b0;
				end else if (!err_q) begin
					if (pending_q == 2'd0) begin
						if (&count_q) begin
							err_q <= 1'b1;
						end else if (q_head.is_ascii) begin
							count_q <= count_q + COUNT_BITS'(1);
						end else if (!q_head.lead_ok) begin
							err_q <= 1'b1;
						end else begin
							kind_q    <= q_head.lead_kind;
							pending_q <= q_head.lead_len;
							second_q  <= 1'b1;
							count_q   <= count_q + COUNT_BITS'(1);
						end
					end else if (cont_ok) begin
						pending_q <= pending_q - 2'd1;
						second_q  <= 1'b0;
					end else begin
						err_q <= 1'b1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/utf8_strict_validate_count_unit.sv */
// Top level: strict UTF-8 validator and codepoint counter.
//
//  channel     dir  payload                          item accepted when
//  byte_in     in   data_byte[7:0]                   valid && ready
//  result_out  out  codepoint_count[30:0], is_valid  valid && ready
//
// One byte per cycle sustained while results are taken; a byte passes the classifier,
// a 4-entry queue and the state update, and a result is registered once its NUL leaves the queue.
// The count adder and full compare in the back end set the cycle time.
// arst_n clears the queue, sequence state, count and the result valid flag.
// A stalled result holds back a NUL at the queue head and the bytes behind it; bytes ahead keep draining.
`timescale 1ns / 1ps
`default_nettype none
module utf8_strict_validate_count_unit #(
	parameter int COUNT_BITS = u8vc_pkg::COUNT_BITS_DEFAULT
) (
	input wire logic       clk,
	input wire logic       arst_n,
	u8vc_byte_if.sink      byte_in,
	u8vc_result_if.source  result_out
);
	import u8vc_pkg::*;

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_not_empty;
	byte_class_t q_item;
	byte_class_t q_head;

	u8vc_front u_front (
		.byte_in (byte_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_item)
	);

	u8vc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (q_head)
	);

	u8vc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.result_out  (result_out)
	);
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench: strict UTF-8 validator and codepoint counter, checked against its own predictor.
`timescale 1ns / 1ps
module tb_top;
	import u8vc_pkg::*;

	localparam int CNT_BITS = COUNT_BITS_DEFAULT;
	localparam longint unsigned CNT_FULL = (64'd1 << CNT_BITS) - 64'd1;
	localparam longint unsigned LONG_CPS = 300;
	localparam int STIM_ITEMS = 1450;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] count;
		logic                   ok;
	} cp_result_t;

	class utf8_count_board;
		logic [1:0]      pend;
		logic [7:0]      lead;
		bit              second;
		longint unsigned cps;
		bit              err;
		cp_result_t      counts_due[$];
		int              errors;

		function void clear_string();
			pend = '0;
			lead = '0;
			second = 1'b0;
			cps = 0;
			err = 1'b0;
		endfunction

		function bit cont_ok(logic [7:0] b);
			logic [7:0] lo;
			logic [7:0] hi;
			lo = CONT_MIN;
			hi = CONT_MAX;
			if (second) begin
				if (lead == LEAD_E0) lo = CONT_E0_LO;
				else if (lead == LEAD_F0) lo = CONT_F0_LO;
				if (lead == LEAD_ED) hi = CONT_ED_HI;
				else if (lead == LEAD_F4) hi = CONT_F4_HI;
			end
			return b >= lo && b <= hi;
		endfunction

		// called for every accepted byte
		function void note_byte(logic [7:0] b);
			cp_result_t r;
			if (b == BYTE_NUL) begin
				r.ok = !err && pend == 0;
				r.count = r.ok ? cps[OUT_COUNT_W-1:0] : '0;
				counts_due.push_back(r);
				clear_string();
				return;
			end
			if (err) return;
			if (pend == 0) begin
				if (cps >= CNT_FULL) begin
					err = 1'b1;
				end else if (b <= ASCII_MAX) begin
					cps++;
				end else if (b < LEAD_MIN || b > LEAD_MAX) begin
					err = 1'b1;
				end else begin
					lead = b;
					pend = (b <= LEAD2_MAX) ? 2'd1 : ((b <= LEAD3_MAX) ? 2'd2 : 2'd3);
					second = 1'b1;
					cps++;
				end
			end else if (cont_ok(b)) begin
				pend = pend - 2'd1;
				second = 1'b0;
			end else begin
				err = 1'b1;
			end
		endfunction

		function void check_count(logic [OUT_COUNT_W-1:0] count, logic ok);
			cp_result_t e;
			if (counts_due.size() == 0) begin
				$display("%0t: unexpected result count=%0d valid=%0b", $time, count, ok);
				errors++;
				return;
			end
			e = counts_due.pop_front();
			if (count !== e.count) begin
				$display("%0t: codepoint_count expected %0d actual %0d", $time, e.count, count);
				errors++;
			end
			if (ok !== e.ok) begin
				$display("%0t: is_valid expected %0b actual %0b", $time, e.ok, ok);
				errors++;
			end
		endfunction

		function int pending();
			return counts_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	u8vc_byte_if   byte_if();
	u8vc_result_if res_if();

	utf8_strict_validate_count_unit #(
		.COUNT_BITS(CNT_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_if),
		.result_out (res_if)
	);

	utf8_count_board board = new;
	logic [7:0] str_q[$];
	int tx_gap_max;
	int rx_stall_max;
	int sent;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Test completed with failures");
		$finish;
	end

	function logic [7:0] rand_byte(int lo, int hi);
		return 8'($urandom_range(lo, hi));
	endfunction

	function logic [7:0] second_of(logic [7:0] lead);
		if (lead == LEAD_E0) return rand_byte(CONT_E0_LO, CONT_MAX);
		if (lead == LEAD_ED) return rand_byte(CONT_MIN, CONT_ED_HI);
		if (lead == LEAD_F0) return rand_byte(CONT_F0_LO, CONT_MAX);
		if (lead == LEAD_F4) return rand_byte(CONT_MIN, CONT_F4_HI);
		return rand_byte(CONT_MIN, CONT_MAX);
	endfunction

	function void add_codepoint();
		int kind;
		logic [7:0] lead;
		kind = $urandom_range(0, 5);
		if (kind <= 2) begin
			str_q.push_back(rand_byte(1, ASCII_MAX));
		end else if (kind == 3) begin
			lead = rand_byte(LEAD_MIN, LEAD2_MAX);
			str_q.push_back(lead);
			str_q.push_back(second_of(lead));
		end else if (kind == 4) begin
			lead = rand_byte(LEAD_E0, LEAD3_MAX);
			str_q.push_back(lead);
			str_q.push_back(second_of(lead));
			str_q.push_back(rand_byte(CONT_MIN, CONT_MAX));
		end else begin
			lead = rand_byte(LEAD_F0, LEAD_F4);
			str_q.push_back(lead);
			str_q.push_back(second_of(lead));
			str_q.push_back(rand_byte(CONT_MIN, CONT_MAX));
			str_q.push_back(rand_byte(CONT_MIN, CONT_MAX));
		end
	endfunction

	// broken strings: corrupted byte, cut-off sequence, or stray byte
	function void build_broken();
		int n;
		int kind;
		int pos;
		logic [7:0] lead;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) add_codepoint();
		kind = $urandom_range(0, 2);
		if (kind == 0) begin
			pos = $urandom_range(0, str_q.size() - 1);
			str_q[pos] = rand_byte(1, 255);
		end else if (kind == 1) begin
			lead = rand_byte(LEAD_MIN, LEAD_MAX);
			str_q.push_back(lead);
			if (lead > LEAD2_MAX) str_q.push_back(second_of(lead));
			if (lead > LEAD3_MAX && $urandom_range(0, 1)) str_q.push_back(rand_byte(CONT_MIN, CONT_MAX));
		end else begin
			str_q.push_back(rand_byte(CONT_MIN, 255));
			n = $urandom_range(0, 4);
			for (int i = 0; i < n; i++) add_codepoint();
		end
	endfunction

	function void build_long(longint unsigned cps);
		for (longint unsigned i = 0; i < cps; i++) begin
			if ($urandom_range(0, 15) == 0) add_codepoint();
			else str_q.push_back(rand_byte(1, ASCII_MAX));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		do @(posedge clk); while (!byte_if.ready);
		board.note_byte(b);
		sent++;
	endtask

	task automatic send_string();
		foreach (str_q[i]) send_byte(str_q[i]);
		str_q.delete();
	endtask

	task automatic drain();
		byte_if.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// result side
	initial begin
		int stall;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			board.check_count(res_if.codepoint_count, res_if.is_valid);
		end
	end

	initial begin
		int n_str;
		int n_long;
		int mode;
		int n;
		arst_n = 1'b0;
		byte_if.valid <= 1'b0;
		byte_if.data_byte <= '0;
		board.clear_string();
		tx_gap_max = 7;
		rx_stall_max = 7;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// range limits of every lead kind
		str_q = '{8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F,
			8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, BYTE_NUL};
		send_string();
		str_q = '{BYTE_NUL};
		send_string();
		// bad lead, later bytes ignored
		str_q = '{8'hF5, 8'h7F, BYTE_NUL};
		send_string();
		str_q = '{8'hE0, 8'h9F, BYTE_NUL};
		send_string();
		str_q = '{8'hF4, 8'h90, BYTE_NUL};
		send_string();
		// string ends inside a sequence
		str_q = '{8'hE1, 8'h80, BYTE_NUL};
		send_string();
		drain();

		n_str = 0;
		n_long = 0;
		while (sent < STIM_ITEMS) begin
			n_str++;
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			if (n_str % 30 == 5) begin
				// long strings, count well past one byte
				if (n_long % 2 == 0) build_long(LONG_CPS);
				else build_long(LONG_CPS + $urandom_range(1, 3));
				n_long++;
			end else begin
				mode = $urandom_range(0, 9);
				if (mode <= 6) begin
					n = $urandom_range(0, 12);
					for (int i = 0; i < n; i++) add_codepoint();
				end else if (mode <= 8) begin
					build_broken();
				end else begin
					n = $urandom_range(1, 12);
					for (int i = 0; i < n; i++) str_q.push_back(rand_byte(1, 255));
				end
			end
			str_q.push_back(BYTE_NUL);
			if ($urandom_range(0, 9) == 0) drain();
			send_string();
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
